>>> rtl/core/gns_pkg.sv
// shared constants, types and fixed-point helpers of the gradient noise sampler
`default_nettype none
package gns_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_RES    = 256;
  localparam int RES_W      = 9;
  localparam int SUB_W      = 8;
  localparam int GRAD_W     = 2;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RES_W;

  // internal signed fixed point, enough headroom for every blend value
  localparam int Q_W   = FRAC_BITS + 6;
  // position t lies in [0, 1], so one integer bit
  localparam int T_W   = FRAC_BITS + 1;
  // divisor is twice the resolution
  localparam int DIV_W = RES_W + 1;
  localparam int NUM_W = SUB_W + 2 + FRAC_BITS;
  localparam int P_W   = 2 * Q_W;

  localparam logic [RES_W-1:0] RES_RESET = RES_W'(16);

  localparam logic signed [Q_W-1:0] ONE_Q  = Q_W'(64'd1 << FRAC_BITS);
  localparam logic signed [P_W-1:0] HALF_P = P_W'(64'd1 << (FRAC_BITS - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESOLUTION = 0,
    CFG_FADE_MODE  = 1
  } cfg_reg_e;

  typedef struct packed {
    logic [GRAD_W-1:0] tl;
    logic [GRAD_W-1:0] tr;
    logic [GRAD_W-1:0] bl;
    logic [GRAD_W-1:0] br;
  } grads_t;

  typedef struct packed {
    logic [T_W-1:0] tx;
    logic [T_W-1:0] ty;
    grads_t         grads;
  } pos_t;

  typedef struct packed {
    logic signed [Q_W-1:0] tx;
    logic signed [Q_W-1:0] ty;
    logic signed [Q_W-1:0] wx;
    logic signed [Q_W-1:0] wy;
    grads_t                grads;
  } weight_t;

  // fixed-point product, rounded to nearest with ties away from zero
  function automatic logic signed [Q_W-1:0] mulq(input logic signed [Q_W-1:0] a,
                                                 input logic signed [Q_W-1:0] b);
    logic signed [P_W-1:0] p;
    logic signed [P_W-1:0] neg;
    logic signed [P_W-1:0] r;
    p   = a * b;
    neg = p[P_W-1] ? P_W'(1) : P_W'(0);
    r   = p + HALF_P - neg;
    return r[FRAC_BITS +: Q_W];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/gns_if.sv
// stream and configuration interfaces of the gradient noise sampler
`default_nettype none
interface gns_in_if;
  logic                         valid;
  logic                         ready;
  logic [gns_pkg::GRAD_W-1:0]   grad_top_left;
  logic [gns_pkg::GRAD_W-1:0]   grad_top_right;
  logic [gns_pkg::GRAD_W-1:0]   grad_bottom_left;
  logic [gns_pkg::GRAD_W-1:0]   grad_bottom_right;
  logic [gns_pkg::SUB_W-1:0]    sub_x;
  logic [gns_pkg::SUB_W-1:0]    sub_y;

  modport source (output valid, grad_top_left, grad_top_right, grad_bottom_left,
                  grad_bottom_right, sub_x, sub_y, input ready);
  modport sink   (input valid, grad_top_left, grad_top_right, grad_bottom_left,
                  grad_bottom_right, sub_x, sub_y, output ready);
endinterface

interface gns_out_if;
  logic                       valid;
  logic                       ready;
  logic [gns_pkg::OUT_W-1:0]  noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

interface gns_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gns_pkg::CFG_IDX_W-1:0]   index;
  logic [gns_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/gradient_noise_sample.sv
// gradient_noise_sample: 2D gradient noise sample, one word per clock while the
// skid register is empty. A word passes 18 divider stages (setup, then one
// quotient bit each), 3 fade, 6 blend stages and the output register, the first
// of them loaded at the accept edge.
// Throughput: one word per cycle while the skid register is empty; the skid
// register keeps input ready independent of the output ready in the same cycle.
// Reset: resolution 16, quintic fade, all pipeline valid bits cleared.
`default_nettype none
module gradient_noise_sample (
  input  logic       clk_i,
  input  logic       rst_ni,
  gns_cfg_if.sink    cfg_i,
  gns_in_if.sink     in_i,
  gns_out_if.source  out_o
);

  logic [gns_pkg::RES_W-1:0] res_q, res_d;
  logic                      mode_q, mode_d;

  logic                      en;
  logic                      div_v, fade_v, blend_v;
  gns_pkg::grads_t           grads;
  gns_pkg::pos_t             pos;
  gns_pkg::weight_t          wgt;
  logic [gns_pkg::OUT_W-1:0] blend_noise;

  logic                      out_v_q, out_v_d;
  logic                      skid_v_q, skid_v_d;
  logic [gns_pkg::OUT_W-1:0] out_q, out_d;
  logic [gns_pkg::OUT_W-1:0] skid_q, skid_d;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_comb begin
    res_d  = res_q;
    mode_d = mode_q;
    if (cfg_i.valid) begin
      unique case (gns_pkg::cfg_reg_e'(cfg_i.index))
        gns_pkg::CFG_RESOLUTION: res_d  = cfg_i.data[gns_pkg::RES_W-1:0];
        gns_pkg::CFG_FADE_MODE:  mode_d = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q  <= gns_pkg::RES_RESET;
      mode_q <= 1'b0;
    end else begin
      res_q  <= res_d;
      mode_q <= mode_d;
    end
  end

  // the whole pipeline holds while the skid register is occupied
  assign en         = !skid_v_q;
  assign in_i.ready = en;

  assign grads.tl = in_i.grad_top_left;
  assign grads.tr = in_i.grad_top_right;
  assign grads.bl = in_i.grad_bottom_left;
  assign grads.br = in_i.grad_bottom_right;

  gns_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .res_i   (res_q),
    .sub_x_i (in_i.sub_x),
    .sub_y_i (in_i.sub_y),
    .grads_i (grads),
    .valid_o (div_v),
    .pos_o   (pos)
  );

  gns_fade u_fade (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .mode_i  (mode_q),
    .valid_i (div_v),
    .pos_i   (pos),
    .valid_o (fade_v),
    .wgt_o   (wgt)
  );

  gns_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fade_v),
    .wgt_i   (wgt),
    .valid_o (blend_v),
    .noise_o (blend_noise)
  );

  // output register with skid
  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (en) begin
      if (!out_v_q || out_o.ready) begin
        out_v_d = blend_v;
        out_d   = blend_noise;
      end else if (blend_v) begin
        skid_v_d = 1'b1;
        skid_d   = blend_noise;
      end
    end else if (out_o.ready) begin
      out_d    = skid_q;
      skid_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid       = out_v_q;
  assign out_o.noise_value = out_q;

endmodule
`default_nettype wire

>>> rtl/core/gns_div.sv
// pipelined restoring divider giving the cell position t on both axes
`default_nettype none
module gns_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [gns_pkg::RES_W-1:0]   res_i,
  input  logic [gns_pkg::SUB_W-1:0]   sub_x_i,
  input  logic [gns_pkg::SUB_W-1:0]   sub_y_i,
  input  gns_pkg::grads_t             grads_i,
  output logic                        valid_o,
  output gns_pkg::pos_t               pos_o
);

  localparam int NST = gns_pkg::T_W + 1;

  logic                          st_v_q   [NST];
  logic                          st_v_d   [NST];
  logic [gns_pkg::DIV_W-1:0]     st_den_q [NST];
  logic [gns_pkg::DIV_W-1:0]     st_den_d [NST];
  logic [gns_pkg::DIV_W-1:0]     st_rem_q [NST][2];
  logic [gns_pkg::DIV_W-1:0]     st_rem_d [NST][2];
  logic [gns_pkg::T_W-1:0]       st_low_q [NST][2];
  logic [gns_pkg::T_W-1:0]       st_low_d [NST][2];
  gns_pkg::grads_t               st_g_q   [NST];
  gns_pkg::grads_t               st_g_d   [NST];

  always_comb begin
    logic [gns_pkg::RES_W-1:0] res_c;
    logic [gns_pkg::SUB_W-1:0] p;
    logic [gns_pkg::NUM_W-1:0] num;
    logic [gns_pkg::DIV_W:0]   trial;
    logic                      ge;

    // clamp resolution into [1, MAX_RES]
    if (res_i == '0) begin
      res_c = gns_pkg::RES_W'(1);
    end else if (res_i > gns_pkg::RES_W'(gns_pkg::MAX_RES)) begin
      res_c = gns_pkg::RES_W'(gns_pkg::MAX_RES);
    end else begin
      res_c = res_i;
    end

    st_v_d[0]   = valid_i;
    st_den_d[0] = {res_c, 1'b0};
    st_g_d[0]   = grads_i;
    for (int l = 0; l < 2; l++) begin
      p = (l == 0) ? sub_x_i : sub_y_i;
      if (gns_pkg::RES_W'(p) >= res_c) begin
        p = gns_pkg::SUB_W'(res_c - gns_pkg::RES_W'(1));
      end
      // (2p + 1) scaled plus res, so the quotient rounds to nearest
      num = (gns_pkg::NUM_W'({p, 1'b1}) << gns_pkg::FRAC_BITS) +
            gns_pkg::NUM_W'(res_c);
      st_rem_d[0][l] = gns_pkg::DIV_W'(num[gns_pkg::NUM_W-1:gns_pkg::T_W]);
      st_low_d[0][l] = num[gns_pkg::T_W-1:0];
    end

    // one quotient bit per stage, shifted in where numerator bits leave
    for (int k = 1; k < NST; k++) begin
      st_v_d[k]   = st_v_q[k-1];
      st_den_d[k] = st_den_q[k-1];
      st_g_d[k]   = st_g_q[k-1];
      for (int l = 0; l < 2; l++) begin
        trial = {st_rem_q[k-1][l], st_low_q[k-1][l][gns_pkg::T_W-1]};
        ge    = (trial >= {1'b0, st_den_q[k-1]});
        st_rem_d[k][l] = ge ? gns_pkg::DIV_W'(trial - {1'b0, st_den_q[k-1]})
                            : trial[gns_pkg::DIV_W-1:0];
        st_low_d[k][l] = {st_low_q[k-1][l][gns_pkg::T_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) st_v_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < NST; k++) st_v_q[k] <= st_v_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NST; k++) begin
        st_den_q[k] <= st_den_d[k];
        st_g_q[k]   <= st_g_d[k];
        for (int l = 0; l < 2; l++) begin
          st_rem_q[k][l] <= st_rem_d[k][l];
          st_low_q[k][l] <= st_low_d[k][l];
        end
      end
    end
  end

  assign valid_o     = st_v_q[NST-1];
  assign pos_o.tx    = st_low_q[NST-1][0];
  assign pos_o.ty    = st_low_q[NST-1][1];
  assign pos_o.grads = st_g_q[NST-1];

endmodule
`default_nettype wire

>>> rtl/core/gns_fade.sv
// fade weight pipeline, quintic curve or linear pass-through per axis
`default_nettype none
module gns_fade (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             mode_i,
  input  logic             valid_i,
  input  gns_pkg::pos_t    pos_i,
  output logic             valid_o,
  output gns_pkg::weight_t wgt_o
);

  localparam logic signed [gns_pkg::Q_W-1:0] SIX_C   = gns_pkg::Q_W'(6);
  localparam logic signed [gns_pkg::Q_W-1:0] FIFTEEN = gns_pkg::Q_W'(15) * gns_pkg::ONE_Q;
  localparam logic signed [gns_pkg::Q_W-1:0] TEN_Q   = gns_pkg::Q_W'(10) * gns_pkg::ONE_Q;

  logic                           vld_q [3];
  logic signed [gns_pkg::Q_W-1:0] s1_t_q [2], s1_t_d [2];
  logic signed [gns_pkg::Q_W-1:0] s1_t2_q[2], s1_t2_d[2];
  logic signed [gns_pkg::Q_W-1:0] s1_h_q [2], s1_h_d [2];
  logic signed [gns_pkg::Q_W-1:0] s2_t_q [2], s2_t_d [2];
  logic signed [gns_pkg::Q_W-1:0] s2_t3_q[2], s2_t3_d[2];
  logic signed [gns_pkg::Q_W-1:0] s2_h_q [2], s2_h_d [2];
  logic signed [gns_pkg::Q_W-1:0] w_d    [2];
  gns_pkg::grads_t                s1_g_q, s2_g_q;
  gns_pkg::weight_t               wgt_q, wgt_d;

  always_comb begin
    logic signed [gns_pkg::Q_W-1:0] t_in;
    for (int l = 0; l < 2; l++) begin
      t_in = (l == 0) ? gns_pkg::Q_W'(pos_i.tx) : gns_pkg::Q_W'(pos_i.ty);
      s1_t_d[l]  = t_in;
      s1_t2_d[l] = gns_pkg::mulq(t_in, t_in);
      s1_h_d[l]  = SIX_C * t_in - FIFTEEN;

      s2_t_d[l]  = s1_t_q[l];
      s2_t3_d[l] = gns_pkg::mulq(s1_t2_q[l], s1_t_q[l]);
      s2_h_d[l]  = gns_pkg::mulq(s1_h_q[l], s1_t_q[l]) + TEN_Q;

      w_d[l] = mode_i ? s2_t_q[l] : gns_pkg::mulq(s2_h_q[l], s2_t3_q[l]);
    end
    wgt_d.tx    = s2_t_q[0];
    wgt_d.ty    = s2_t_q[1];
    wgt_d.wx    = w_d[0];
    wgt_d.wy    = w_d[1];
    wgt_d.grads = s2_g_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
      vld_q[1] <= 1'b0;
      vld_q[2] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      vld_q[1] <= vld_q[0];
      vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        s1_t_q[l]  <= s1_t_d[l];
        s1_t2_q[l] <= s1_t2_d[l];
        s1_h_q[l]  <= s1_h_d[l];
        s2_t_q[l]  <= s2_t_d[l];
        s2_t3_q[l] <= s2_t3_d[l];
        s2_h_q[l]  <= s2_h_d[l];
      end
      s1_g_q <= pos_i.grads;
      s2_g_q <= s1_g_q;
      wgt_q  <= wgt_d;
    end
  end

  assign valid_o = vld_q[2];
  assign wgt_o   = wgt_q;

endmodule
`default_nettype wire

>>> rtl/core/gns_blend.sv
// corner dot products, x and y blends and Q0.16 output scaling
`default_nettype none
module gns_blend (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  gns_pkg::weight_t            wgt_i,
  output logic                        valid_o,
  output logic [gns_pkg::OUT_W-1:0]   noise_o
);

  localparam int OUT_SH = gns_pkg::FRAC_BITS + 1 - gns_pkg::OUT_W;
  localparam int SC_W   = gns_pkg::Q_W + gns_pkg::OUT_W;

  typedef logic signed [gns_pkg::Q_W-1:0] q_t;

  function automatic q_t dot(input logic [gns_pkg::GRAD_W-1:0] g, input q_t dx,
                             input q_t dy);
    q_t x;
    q_t y;
    x = g[0] ? dx : -dx;
    y = g[1] ? dy : -dy;
    return x + y;
  endfunction

  logic vld_q [6];

  q_t b1_v_q [4];
  q_t b1_wx_q, b1_wy_q;
  q_t b2_d1_q, b2_d2_q, b2_v1_q, b2_v3_q, b2_wx_q, b2_wy_q;
  q_t b3_n1_q, b3_n2_q, b3_wy_q;
  q_t b4_dn_q, b4_n1_q, b4_wy_q;
  q_t b5_r_q;
  logic [gns_pkg::OUT_W-1:0] noise_q, noise_d;

  q_t                  tx1, ty1, s_val;
  logic [SC_W-1:0]     scaled;

  assign tx1   = wgt_i.tx - gns_pkg::ONE_Q;
  assign ty1   = wgt_i.ty - gns_pkg::ONE_Q;
  assign s_val = b5_r_q + gns_pkg::ONE_Q;

  // halve s and bring it to the output fraction width
  if (OUT_SH > 0) begin : g_round
    localparam logic [SC_W-1:0] RND = SC_W'(1) << (OUT_SH - 1);
    assign scaled = (SC_W'(unsigned'(s_val)) + RND) >> OUT_SH;
  end else begin : g_widen
    assign scaled = SC_W'(unsigned'(s_val)) << (-OUT_SH);
  end

  always_comb begin
    if (s_val <= 0) begin
      noise_d = '0;
    end else if (scaled > SC_W'({gns_pkg::OUT_W{1'b1}})) begin
      noise_d = '1;
    end else begin
      noise_d = scaled[gns_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < 6; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_v_q[0] <= dot(wgt_i.grads.tl, wgt_i.tx, wgt_i.ty);
      b1_v_q[1] <= dot(wgt_i.grads.tr, tx1, wgt_i.ty);
      b1_v_q[2] <= dot(wgt_i.grads.bl, wgt_i.tx, ty1);
      b1_v_q[3] <= dot(wgt_i.grads.br, tx1, ty1);
      b1_wx_q   <= wgt_i.wx;
      b1_wy_q   <= wgt_i.wy;

      b2_d1_q <= b1_v_q[1] - b1_v_q[0];
      b2_d2_q <= b1_v_q[3] - b1_v_q[2];
      b2_v1_q <= b1_v_q[0];
      b2_v3_q <= b1_v_q[2];
      b2_wx_q <= b1_wx_q;
      b2_wy_q <= b1_wy_q;

      b3_n1_q <= gns_pkg::mulq(b2_d1_q, b2_wx_q) + b2_v1_q;
      b3_n2_q <= gns_pkg::mulq(b2_d2_q, b2_wx_q) + b2_v3_q;
      b3_wy_q <= b2_wy_q;

      b4_dn_q <= b3_n2_q - b3_n1_q;
      b4_n1_q <= b3_n1_q;
      b4_wy_q <= b3_wy_q;

      b5_r_q  <= gns_pkg::mulq(b4_dn_q, b4_wy_q) + b4_n1_q;

      noise_q <= noise_d;
    end
  end

  assign valid_o = vld_q[5];
  assign noise_o = noise_q;

endmodule
`default_nettype wire

>>> tb/gradient_noise_sample_tb.sv
// testbench of the gradient noise sampler: directed and random words checked against a predictor
`default_nettype none
module gradient_noise_sample_tb;
  import gns_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  // cycles run at the end after all expected results have arrived
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_WORDS = 170;

  // indexes with no register behind them, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam longint Q_ONE  = longint'(1) <<< FRAC_BITS;
  localparam longint Q_HALF = longint'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    grads_t           grads;
    logic [SUB_W-1:0] sub_x;
    logic [SUB_W-1:0] sub_y;
  } noise_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gns_cfg_if cfg_if ();
  gns_in_if  in_if ();
  gns_out_if out_if ();

  gradient_noise_sample u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // register copies as the block should hold them
  logic [RES_W-1:0] res_reg = RES_RESET;
  logic             linear_fade = 1'b0;

  logic [OUT_W-1:0] noise_due_q[$];
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_stall_pct = 0;
  int unsigned      errors = 0;
  int unsigned      cycle_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // product of two fixed-point values, nearest with ties away from zero
  function automatic longint fix_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    if (p >= 0) return (p + Q_HALF) >>> FRAC_BITS;
    return -((-p + Q_HALF) >>> FRAC_BITS);
  endfunction

  function automatic longint eff_res();
    longint res;
    res = longint'(res_reg);
    if (res == 0) res = 1;
    if (res > MAX_RES) res = MAX_RES;
    return res;
  endfunction

  // sample center inside the cell, rounded to nearest
  function automatic longint cell_position(input longint p, input longint res);
    if (p >= res) p = res - 1;
    return (((2 * p + 1) <<< FRAC_BITS) + res) / (2 * res);
  endfunction

  function automatic longint fade_weight(input longint t);
    longint h;
    longint t3;
    if (linear_fade) return t;
    h  = 6 * t - 15 * Q_ONE;
    h  = fix_mul(h, t) + 10 * Q_ONE;
    t3 = fix_mul(fix_mul(t, t), t);
    return fix_mul(h, t3);
  endfunction

  function automatic longint corner_dot(input logic [GRAD_W-1:0] g, input longint dx,
                                        input longint dy);
    return (g[0] ? dx : -dx) + (g[1] ? dy : -dy);
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint w);
    return fix_mul(b - a, w) + a;
  endfunction

  function automatic logic [OUT_W-1:0] noise_sample(input noise_req_t req);
    longint res, tx, ty, wx, wy, top, bot, r, s, q;
    res = eff_res();
    tx  = cell_position(longint'(req.sub_x), res);
    ty  = cell_position(longint'(req.sub_y), res);
    wx  = fade_weight(tx);
    wy  = fade_weight(ty);
    top = blend(corner_dot(req.grads.tl, tx, ty),
                corner_dot(req.grads.tr, tx - Q_ONE, ty), wx);
    bot = blend(corner_dot(req.grads.bl, tx, ty - Q_ONE),
                corner_dot(req.grads.br, tx - Q_ONE, ty - Q_ONE), wx);
    r   = blend(top, bot, wy);
    // map [-1, 1] onto [0, 1) with 16 fraction bits, rounding half up
    s   = r + Q_ONE;
    if (s <= 0) return '0;
    q = (s + 1) >>> 1;
    if (q > 65535) return '1;
    return q[OUT_W-1:0];
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic noise_req_t make_req(input logic [4*GRAD_W-1:0] g,
                                          input logic [SUB_W-1:0] sx,
                                          input logic [SUB_W-1:0] sy);
    noise_req_t req;
    req.grads = grads_t'(g);
    req.sub_x = sx;
    req.sub_y = sy;
    return req;
  endfunction

  // each cycle before the word is idle with the sender idle percentage
  task automatic push_sample(input noise_req_t req);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid             <= 1'b1;
    in_if.grad_top_left     <= req.grads.tl;
    in_if.grad_top_right    <= req.grads.tr;
    in_if.grad_bottom_left  <= req.grads.bl;
    in_if.grad_bottom_right <= req.grads.br;
    in_if.sub_x             <= req.sub_x;
    in_if.sub_y             <= req.sub_y;
    do @(posedge clk_i); while (!in_if.ready);
    noise_due_q.push_back(noise_sample(req));
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (noise_due_q.size() != 0);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_RESOLUTION: res_reg = data[RES_W-1:0];
      CFG_FADE_MODE:  linear_fade = data[0];
      default: ;
    endcase
  endtask

  // only called with the pipeline empty; the spare write goes last so aliasing shows up
  task automatic set_config(input logic [CFG_DATA_W-1:0] res_data,
                            input logic [CFG_DATA_W-1:0] fade_data,
                            input logic [CFG_IDX_W-1:0] spare_idx,
                            input logic [CFG_DATA_W-1:0] spare_data);
    put_reg(CFG_RESOLUTION, res_data);
    put_reg(CFG_FADE_MODE, fade_data);
    put_reg(spare_idx, spare_data);
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin : check_p
    logic [OUT_W-1:0] want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (noise_due_q.size() == 0) begin
        $display("%0t: unexpected noise word, expected none, actual %h",
                 $time, out_if.noise_value);
        errors++;
      end else begin
        want = noise_due_q.pop_front();
        if (out_if.noise_value !== want) begin
          $display("%0t: noise_value mismatch, expected %h, actual %h",
                   $time, want, out_if.noise_value);
          errors++;
        end
      end
    end
    out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    push_sample(make_req(8'h00, 8'd0, 8'd0));
    push_sample(make_req(8'hFF, 8'd15, 8'd15));
    push_sample(make_req(8'h1B, 8'd16, 8'd255));
    push_sample(make_req(8'hE4, 8'd7, 8'd8));
    wait_for_results();
  endtask

  task automatic test_resolution_limits();
    tx_idle_pct  = 19;
    rx_stall_pct = 19;
    // zero acts as one sample per cell
    set_config(9'd0, 9'd0, CFG_SPARE_A, 9'h1FF);
    push_sample(make_req(8'h00, 8'd0, 8'd0));
    push_sample(make_req(8'hFF, 8'd255, 8'd255));
    wait_for_results();
    // above the maximum clamps to it
    set_config(9'd511, 9'd0, CFG_SPARE_B, 9'h0AA);
    push_sample(make_req(8'h39, 8'd255, 8'd0));
    push_sample(make_req(8'hC6, 8'd0, 8'd255));
    push_sample(make_req(8'h4E, 8'd128, 8'd127));
    wait_for_results();
    set_config(9'd257, 9'd0, CFG_SPARE_A, 9'h155);
    push_sample(make_req(8'h93, 8'd200, 8'd55));
    wait_for_results();
    set_config(9'd1, 9'd0, CFG_SPARE_B, 9'h1FF);
    push_sample(make_req(8'hB1, 8'd0, 8'd0));
    push_sample(make_req(8'h6C, 8'd1, 8'd254));
    wait_for_results();
    set_config(9'd256, 9'd1, CFG_SPARE_A, 9'h000);
    push_sample(make_req(8'hFF, 8'd255, 8'd255));
    push_sample(make_req(8'h00, 8'd0, 8'd128));
    wait_for_results();
  endtask

  task automatic test_fade_modes();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // only bit 0 of the fade word counts
    set_config(9'd16, 9'h1FF, CFG_SPARE_A, 9'h000);
    push_sample(make_req(8'h1B, 8'd0, 8'd15));
    push_sample(make_req(8'hE4, 8'd8, 8'd7));
    push_sample(make_req(8'h72, 8'd15, 8'd3));
    wait_for_results();
    set_config(9'd3, 9'h1FE, CFG_SPARE_B, 9'h155);
    push_sample(make_req(8'h8D, 8'd0, 8'd2));
    push_sample(make_req(8'h27, 8'd1, 8'd1));
    push_sample(make_req(8'hD8, 8'd9, 8'd0));
    wait_for_results();
  endtask

  task automatic test_random_stream();
    logic [CFG_DATA_W-1:0] res_data;
    logic [SUB_W-1:0]      sx;
    logic [SUB_W-1:0]      sy;
    longint                res;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 76; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 76; end
        default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
      endcase
      case ($urandom_range(0, 7))
        0: res_data = 9'd1;
        1: res_data = 9'd2;
        2: res_data = 9'd16;
        3: res_data = 9'd255;
        4: res_data = 9'd256;
        5: res_data = 9'd0;
        6: res_data = CFG_DATA_W'($urandom_range(257, 511));
        default: res_data = CFG_DATA_W'($urandom_range(1, 256));
      endcase
      set_config(res_data, CFG_DATA_W'($urandom_range(0, 511)),
                 (ph % 2 == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                 CFG_DATA_W'($urandom_range(0, 511)));
      res = eff_res();
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // mostly positions inside the cell, some past its edge
        if ($urandom_range(0, 99) < 85) begin
          sx = SUB_W'($urandom_range(0, 32'(res - 1)));
          sy = SUB_W'($urandom_range(0, 32'(res - 1)));
        end else begin
          sx = SUB_W'($urandom_range(0, 255));
          sy = SUB_W'($urandom_range(0, 255));
        end
        push_sample(make_req(8'($urandom_range(0, 255)), sx, sy));
        if ($urandom_range(0, 199) == 0) wait_for_results();
      end
      wait_for_results();
    end
  endtask

  initial begin
    rst_ni                  <= 1'b0;
    cfg_if.valid            <= 1'b0;
    cfg_if.index            <= CFG_RESOLUTION;
    cfg_if.data             <= '0;
    in_if.valid             <= 1'b0;
    in_if.grad_top_left     <= '0;
    in_if.grad_top_right    <= '0;
    in_if.grad_bottom_left  <= '0;
    in_if.grad_bottom_right <= '0;
    in_if.sub_x             <= '0;
    in_if.sub_y             <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_resolution_limits();
    test_fade_modes();
    test_random_stream();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
